// ----- hdl/sfgc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfgc_pkg - shared definitions of the state feedback gain controller
// Stream field widths, fixed point constants of the angle wrap and the
// control types carried along the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sfgc_pkg;

  // Shape of the gain matrix and fixed point format
  localparam int FRAC_BITS    = 16;
  localparam int STATE_COUNT  = 12;
  localparam int OUTPUT_COUNT = 4;
  localparam int GAIN_WORDS   = STATE_COUNT * OUTPUT_COUNT;

  localparam int IDX_W  = 6;
  localparam int COL_W  = $clog2(STATE_COUNT);
  localparam int ROW_W  = $clog2(OUTPUT_COUNT);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 18;
  localparam int ACC_W  = 64;
  localparam int PROD_W = 2 * DATA_W;
  localparam int DIFF_W = DATA_W + 2;

  // Stream widths
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = OUTPUT_COUNT * CMD_W;

  // Item kinds on in_tuser[0]
  localparam logic FUNC_GAIN  = 1'b0;
  localparam logic FUNC_STATE = 1'b1;

  // State element groups
  localparam int IDX_VEL_LO   = 3;
  localparam int IDX_ATT_LO   = 6;
  localparam int IDX_PITCH    = 7;
  localparam int IDX_YAW      = 8;
  localparam int IDX_RATE_LO  = 9;

  // pi and 2*pi, rounded to FRAC_BITS fractional bits
  localparam longint PI_Q32     = 64'sd13493037705;
  localparam longint TWO_PI_Q32 = 64'sd26986075409;
  localparam longint PI_FX = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint TP_FX = (TWO_PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  // an even 2*pi leaves a half-open wrap interval that differs by side
  localparam bit     TP_EVEN = (TP_FX == 2 * PI_FX);

  // Remainder by 2*pi: bias to a positive value, reciprocal quotient estimate
  localparam int     U_W     = DATA_W + 3;
  localparam longint OFF_FX  = TP_FX * ((64'sd1 <<< (DATA_W + 1)) / TP_FX + 1);
  localparam longint RECIP   = (64'sd1 <<< U_W) / TP_FX;
  localparam int     RECIP_W = $clog2(RECIP + 1);
  localparam int     TP_W    = $clog2(TP_FX + 1);
  localparam int     WS_W    = TP_W + 2;

  // Output scaling
  localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;
  localparam int     SH_R   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int     SH_L   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // How one element forms its error
  typedef enum logic [1:0] {
    ES_LIN,
    ES_WRAP,
    ES_ZERO
  } err_sel_t;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic vld;
    logic acc_en;
    logic last;
    logic gok;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hdl/sfgc_wrap.sv -----
// ----------------------------------------------------------------------------
// sfgc_wrap - angle wrap into [-pi, pi]
// Two registered stages: quotient estimate by reciprocal multiply, then the
// remainder; one compare and subtract finishes it at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sfgc_wrap (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [sfgc_pkg::U_W-1:0]          u_i,
  input  wire logic                              gt_i,
  output logic signed [sfgc_pkg::DATA_W-1:0]     wrap_o
);
  import sfgc_pkg::*;

  logic [U_W+RECIP_W-1:0] qprod;
  logic [RECIP_W-1:0]     q_nxt;
  logic [RECIP_W-1:0]     q_r;
  logic [U_W-1:0]         u_r;
  logic                   gt1_r;
  logic [U_W:0]           rprod;
  logic [U_W:0]           rdiff;
  logic [TP_W:0]          r0_r;
  logic                   gt2_r;
  logic [TP_W:0]          rem;
  logic signed [WS_W-1:0] ws;

  // Estimate floor(u / 2pi); it is exact or one low
  assign qprod = (U_W+RECIP_W)'(u_i) * (U_W+RECIP_W)'(RECIP);
  assign q_nxt = qprod[U_W+RECIP_W-1:U_W];

  // Remainder against the estimate, below twice 2pi
  assign rprod = (U_W+1)'(q_r) * (U_W+1)'(TP_FX);
  assign rdiff = (U_W+1)'(u_r) - rprod;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= q_nxt;
      u_r   <= u_i;
      gt1_r <= gt_i;
      r0_r  <= rdiff[TP_W:0];
      gt2_r <= gt1_r;
    end
  end

  // Correct the estimate, drop the pi bias
  always_comb begin
    rem = r0_r;
    if (r0_r >= (TP_W+1)'(TP_FX)) begin
      rem = r0_r - (TP_W+1)'(TP_FX);
    end
    ws = $signed({1'b0, rem}) - $signed(WS_W'(PI_FX));
    if (TP_EVEN && gt2_r && (ws == -$signed(WS_W'(PI_FX)))) begin
      ws = $signed(WS_W'(PI_FX));
    end
    wrap_o = DATA_W'(ws);
  end

endmodule

`default_nettype wire

// ----- hdl/state_feedback_gain_controller_core.sv -----
// ----------------------------------------------------------------------------
// state_feedback_gain_controller_core - 4 x 12 state feedback controller
// Gain words load a gain store; state elements are turned into errors,
// multiplied by their gain column and summed into four saturated commands.
// ----------------------------------------------------------------------------
// The block takes one item per clock: in_tuser[0] low writes one gain word
// at index row*12+column, high supplies one state element. Items flow through
// an eight-stage pipeline (input register, error and gain read, two angle
// wrap stages, error select, four parallel 32x32 multiplies, accumulate,
// output scaling). Sustained rate is one item per cycle; in_tready drops only
// while a finished result sits in the accumulate stage and the output register
// still holds an earlier result that is not taken. Gain writes take effect for
// every state element accepted after them. The gain store reads as zero after
// reset; out_tuser reports whether any gain is nonzero and, when it is not,
// all four commands are zero.
`default_nettype none

module state_feedback_gain_controller_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // index[5:0], gain[37:6], desired[69:38], measured[101:70], zero fill
  input  wire logic [sfgc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[0], hold[1]
  input  wire logic [sfgc_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // thrust_cmd[17:0], roll_cmd[35:18], pitch_cmd[53:36], yaw_cmd[71:54]
  output logic [sfgc_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // gains_ok[0]
  output logic                                     out_tuser
);
  import sfgc_pkg::*;

  typedef logic [OUTPUT_COUNT-1:0][DATA_W-1:0] gvec_t;

  logic en;

  // Input register
  logic                     s0_vld_r;
  logic                     s0_func_r;
  logic                     s0_hold_r;
  logic                     s0_last_r;
  logic [IDX_W-1:0]         s0_idx_r;
  logic [DATA_W-1:0]        s0_gain_r;
  logic signed [DATA_W-1:0] s0_des_r;
  logic signed [DATA_W-1:0] s0_meas_r;

  // Gain store and nonzero flags
  logic [DATA_W-1:0]                          gain_mem [OUTPUT_COUNT][STATE_COUNT];
  logic [OUTPUT_COUNT-1:0][STATE_COUNT-1:0]   nz_r;
  logic                                       gwr;
  logic [ROW_W-1:0]                           wr_row;
  logic [COL_W-1:0]                           wr_col;
  logic [COL_W-1:0]                           rd_col;

  // Stage 0 decode
  logic                     st_ok;
  logic                     des_zero;
  logic signed [DIFF_W-1:0] d_nxt;
  logic signed [U_W:0]      u_s;
  err_sel_t                 sel_nxt;
  ctl_t                     ctl_nxt;

  // Pipeline registers
  ctl_t                     s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r;
  err_sel_t                 s1_sel_r, s2_sel_r, s3_sel_r;
  logic signed [DIFF_W-1:0] s1_d_r, s2_d_r, s3_d_r;
  logic [U_W-1:0]           s1_u_r;
  logic                     s1_gt_r;
  gvec_t                    g1_r, g2_r, g3_r, g4_r;
  logic signed [DATA_W-1:0] err_nxt;
  logic signed [DATA_W-1:0] err_r;
  logic signed [DATA_W-1:0] wrap_val;
  logic signed [PROD_W-1:0] prod_r [OUTPUT_COUNT];

  // Accumulators and final stage
  logic signed [ACC_W-1:0]  acc_r   [OUTPUT_COUNT];
  logic signed [ACC_W-1:0]  acc_nxt [OUTPUT_COUNT];
  logic signed [ACC_W-1:0]  f_acc_r [OUTPUT_COUNT];
  logic                     f_vld_r;
  logic                     f_gok_r;

  // Output register
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;
  logic                     out_tuser_r;
  logic                     out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   cmd_nxt;

  // Advance unless a result is blocked at the output
  assign en        = !(f_vld_r && out_tvalid_r && !out_tready);
  assign in_tready = en;

  // Capture the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func_r <= in_tuser[0];
      s0_hold_r <= in_tuser[1];
      s0_last_r <= in_tlast;
      s0_idx_r  <= in_tdata[5:0];
      s0_gain_r <= in_tdata[37:6];
      s0_des_r  <= $signed(in_tdata[69:38]);
      s0_meas_r <= $signed(in_tdata[101:70]);
    end
  end

  // Split a gain index into row and column
  always_comb begin
    if (s0_idx_r >= IDX_W'(3 * STATE_COUNT)) begin
      wr_row = ROW_W'(3);
      wr_col = COL_W'(s0_idx_r - IDX_W'(3 * STATE_COUNT));
    end else if (s0_idx_r >= IDX_W'(2 * STATE_COUNT)) begin
      wr_row = ROW_W'(2);
      wr_col = COL_W'(s0_idx_r - IDX_W'(2 * STATE_COUNT));
    end else if (s0_idx_r >= IDX_W'(STATE_COUNT)) begin
      wr_row = ROW_W'(1);
      wr_col = COL_W'(s0_idx_r - IDX_W'(STATE_COUNT));
    end else begin
      wr_row = ROW_W'(0);
      wr_col = COL_W'(s0_idx_r);
    end
  end

  assign gwr    = s0_vld_r && (s0_func_r == FUNC_GAIN) && (s0_idx_r < IDX_W'(GAIN_WORDS));
  assign st_ok  = s0_idx_r < IDX_W'(STATE_COUNT);
  assign rd_col = st_ok ? COL_W'(s0_idx_r) : '0;

  // Form the raw difference and pick how the error is made
  always_comb begin
    des_zero = (s0_idx_r >= IDX_W'(IDX_RATE_LO)) ||
               (s0_hold_r && (s0_idx_r >= IDX_W'(IDX_VEL_LO)) &&
                (s0_idx_r <= IDX_W'(IDX_PITCH)));
    d_nxt = (des_zero ? '0 : DIFF_W'(s0_des_r)) - DIFF_W'(s0_meas_r);
    u_s   = (U_W+1)'(d_nxt) + (U_W+1)'(PI_FX + OFF_FX);
    if (s0_idx_r >= IDX_W'(IDX_RATE_LO)) begin
      sel_nxt = ES_LIN;
    end else if (s0_idx_r >= IDX_W'(IDX_ATT_LO)) begin
      sel_nxt = (s0_hold_r && (s0_idx_r == IDX_W'(IDX_YAW))) ? ES_ZERO : ES_WRAP;
    end else begin
      sel_nxt = ES_LIN;
    end
    ctl_nxt.vld    = s0_vld_r && (s0_func_r == FUNC_STATE);
    ctl_nxt.acc_en = st_ok;
    ctl_nxt.last   = s0_last_r;
    ctl_nxt.gok    = |nz_r;
  end

  // Gain store: write one word, read one column
  always_ff @(posedge clk) begin
    if (en) begin
      if (gwr) begin
        gain_mem[wr_row][wr_col] <= s0_gain_r;
      end
      for (int r = 0; r < OUTPUT_COUNT; r++) begin
        g1_r[r] <= nz_r[r][rd_col] ? gain_mem[r][rd_col] : '0;
      end
    end
  end

  // Track which gains are nonzero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r <= '0;
    end else if (en && gwr) begin
      nz_r[wr_row][wr_col] <= (s0_gain_r != '0);
    end
  end

  // Control through the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= ctl_nxt;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
      s5_ctl_r <= s4_ctl_r;
    end
  end

  // Payload through the pipe
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sel_r <= sel_nxt;
      s1_d_r   <= d_nxt;
      s1_u_r   <= u_s[U_W-1:0];
      s1_gt_r  <= d_nxt > $signed(DIFF_W'(PI_FX));
      s2_sel_r <= s1_sel_r;
      s2_d_r   <= s1_d_r;
      g2_r     <= g1_r;
      s3_sel_r <= s2_sel_r;
      s3_d_r   <= s2_d_r;
      g3_r     <= g2_r;
      err_r    <= err_nxt;
      g4_r     <= g3_r;
      for (int r = 0; r < OUTPUT_COUNT; r++) begin
        prod_r[r] <= PROD_W'(err_r) * PROD_W'($signed(g4_r[r]));
      end
    end
  end

  sfgc_wrap u_wrap (
    .clk    (clk),
    .en     (en),
    .u_i    (s1_u_r),
    .gt_i   (s1_gt_r),
    .wrap_o (wrap_val)
  );

  // Select the error, saturate a plain difference to 32 bits
  always_comb begin
    case (s3_sel_r)
      ES_WRAP: err_nxt = wrap_val;
      ES_ZERO: err_nxt = '0;
      default: begin
        if ((s3_d_r[DIFF_W-1:DATA_W-1] == '0) || (s3_d_r[DIFF_W-1:DATA_W-1] == '1)) begin
          err_nxt = s3_d_r[DATA_W-1:0];
        end else if (s3_d_r[DIFF_W-1]) begin
          err_nxt = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          err_nxt = {1'b0, {(DATA_W-1){1'b1}}};
        end
      end
    endcase
  end

  // Add the scaled products with 64-bit saturation
  always_comb begin
    logic signed [PROD_W-1:0] ps;
    logic signed [ACC_W:0]    sum;
    for (int r = 0; r < OUTPUT_COUNT; r++) begin
      ps  = prod_r[r] >>> FRAC_BITS;
      sum = (ACC_W+1)'(acc_r[r]) + (ACC_W+1)'(ps);
      if (!(s5_ctl_r.vld && s5_ctl_r.acc_en)) begin
        acc_nxt[r] = acc_r[r];
      end else if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt[r] = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt[r] = sum[ACC_W-1:0];
      end
    end
  end

  // Accumulate; hand the sums on and clear at the end of a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      for (int r = 0; r < OUTPUT_COUNT; r++) begin
        acc_r[r] <= '0;
      end
    end else if (en) begin
      f_vld_r <= s5_ctl_r.vld && s5_ctl_r.last;
      for (int r = 0; r < OUTPUT_COUNT; r++) begin
        acc_r[r] <= (s5_ctl_r.vld && s5_ctl_r.last) ? '0 : acc_nxt[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_gok_r <= s5_ctl_r.gok;
      for (int r = 0; r < OUTPUT_COUNT; r++) begin
        f_acc_r[r] <= acc_nxt[r];
      end
    end
  end

  // Clamp to plus or minus one and scale to 16 fractional bits
  always_comb begin
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] v;
    for (int r = 0; r < OUTPUT_COUNT; r++) begin
      if (f_acc_r[r] > ACC_W'(ONE_FX)) begin
        c = ACC_W'(ONE_FX);
      end else if (f_acc_r[r] < -ACC_W'(ONE_FX)) begin
        c = -ACC_W'(ONE_FX);
      end else begin
        c = f_acc_r[r];
      end
      v = (c >>> SH_R) <<< SH_L;
      cmd_nxt[r*CMD_W +: CMD_W] = f_gok_r ? v[CMD_W-1:0] : '0;
    end
  end

  // Output register
  assign out_tvalid_nxt = (out_tvalid_r && !out_tready) || (en && f_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && f_vld_r) begin
      out_tdata_r <= cmd_nxt;
      out_tuser_r <= f_gok_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// ----- hdl/sfgc_checker.sv -----
// ----------------------------------------------------------------------------
// sfgc_checker - port-level checks of the state feedback gain controller
// Watches the result stream for held results, command range and the
// forced-zero case; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module sfgc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [sfgc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire logic                                out_tuser
);
  import sfgc_pkg::*;

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Commands stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[17:0])  <= 18'sd65536) && ($signed(out_tdata[17:0])  >= -18'sd65536) &&
      ($signed(out_tdata[35:18]) <= 18'sd65536) && ($signed(out_tdata[35:18]) >= -18'sd65536) &&
      ($signed(out_tdata[53:36]) <= 18'sd65536) && ($signed(out_tdata[53:36]) >= -18'sd65536) &&
      ($signed(out_tdata[71:54]) <= 18'sd65536) && ($signed(out_tdata[71:54]) >= -18'sd65536))
    else $error("command out of range");

  // No nonzero gain means all commands zero
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == '0))
    else $error("nonzero command without gains");

endmodule

bind state_feedback_gain_controller_core sfgc_checker u_sfgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
